/* hdl/egodo_pkg.sv */
// Shared constants, types and helpers for the encoder/gyro odometry block.
// No dependencies; the register file, divider and top-level files import this package.
package egodo_pkg;

    // field widths
    localparam int ENC_W  = 12;
    localparam int FRAC_W = 16;
    localparam int CFG_W  = 16;
    localparam int GYRO_W = 16;
    localparam int SPD_W  = 32;
    localparam int ACC_W  = 48;

    // datapath widths
    localparam int RAW_W   = ENC_W + CFG_W + 1;     // count delta times mm per pulse
    localparam int GDIF_W  = GYRO_W + 1;            // offset minus sample
    localparam int G_W     = GDIF_W + 7;            // times 70, millideg/s
    localparam int RADC_W  = 18;
    localparam int LPN_W   = SPD_W + 5;             // raw + 9*old + 5
    localparam int HDN_W   = G_W + FRAC_W + 1;      // g*2^F + 500000
    localparam int RR_W    = G_W + RADC_W;          // g times rad-per-mdeg constant

    // serial radix-4 divider
    localparam int DIV_NUM_W  = 40;
    localparam int DIV_DEN_W  = 20;
    localparam int DIV_DIGITS = DIV_NUM_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_DIGITS);

    localparam logic [DIV_DEN_W-1:0]    LP_DEN    = 20'd10;
    localparam logic [DIV_DEN_W-1:0]    HEAD_DEN  = 20'd1000000;
    localparam logic [RADC_W-1:0]       RAD_PER_MDEG_Q32 = 18'd74961;
    localparam logic signed [LPN_W-1:0] LP_BIAS   = 37'sd5;
    localparam logic signed [HDN_W-1:0] HEAD_BIAS = 41'sd500000;
    localparam logic signed [RR_W-1:0]  RATE_BIAS = 42'sd32768;   // 2^(31-F)
    localparam int RATE_SHIFT = 32 - FRAC_W;

    // register port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [CFG_W-1:0] MMPP_RESET = 16'd1311;

    typedef enum logic {
        REG_GYRO_OFFSET  = 1'b0,
        REG_MM_PER_PULSE = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic signed [GYRO_W-1:0] gyro_offset;
        logic [CFG_W-1:0]         mm_per_pulse;
    } t_cfg;

    typedef struct packed {
        logic done;
        logic rem_nz;
    } t_div_stat;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
        logic signed [ACC_W-1:0] res;
        if (v[ACC_W] != v[ACC_W-1]) begin
            res = v[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            res = v[ACC_W-1:0];
        end
        return res;
    endfunction

endpackage

/* hdl/egodo_cfg.sv */
// APB-style register file: gyro offset and wheel travel per count.
// Depends on egodo_pkg.
module egodo_cfg import egodo_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic signed [GYRO_W-1:0] r_gyro_offset;
    logic [CFG_W-1:0]         r_mm_per_pulse;
    t_reg_idx                 w_idx;
    logic                     w_wr;

    // word addressing, low two bits ignored
    assign w_idx  = t_reg_idx'(paddr[APB_AW-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro_offset  <= '0;
            r_mm_per_pulse <= MMPP_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_GYRO_OFFSET:  r_gyro_offset  <= pwdata[GYRO_W-1:0];
                REG_MM_PER_PULSE: r_mm_per_pulse <= pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_GYRO_OFFSET:  prdata = {{(APB_DW-GYRO_W){1'b0}}, r_gyro_offset};
            REG_MM_PER_PULSE: prdata = {{(APB_DW-CFG_W){1'b0}}, r_mm_per_pulse};
        endcase
    end

    assign o_cfg.gyro_offset  = r_gyro_offset;
    assign o_cfg.mm_per_pulse = r_mm_per_pulse;

endmodule

/* hdl/egodo_div.sv */
// Radix-4 restoring divider: unsigned numerator shifted in two bits per cycle.
// Depends on egodo_pkg. Quotient and remainder flag valid with the done pulse.
module egodo_div import egodo_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic [DIV_NUM_W-1:0] o_quot,
    output t_div_stat            o_stat
);

    localparam int TW = DIV_DEN_W + 2;

    logic [DIV_NUM_W-1:0] r_shift;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [TW-1:0] w_trial;
    logic [TW-1:0] w_d1;
    logic [TW-1:0] w_d2;
    logic [TW-1:0] w_d3;
    logic [TW-1:0] w_diff;
    logic [1:0]    w_digit;

    always_comb begin
        w_trial = {r_rem, r_shift[DIV_NUM_W-1 -: 2]};
        w_d1    = TW'(i_den);
        w_d2    = TW'({i_den, 1'b0});
        w_d3    = w_d1 + w_d2;
        if (w_trial >= w_d3) begin
            w_digit = 2'd3;
            w_diff  = w_trial - w_d3;
        end else if (w_trial >= w_d2) begin
            w_digit = 2'd2;
            w_diff  = w_trial - w_d2;
        end else if (w_trial >= w_d1) begin
            w_digit = 2'd1;
            w_diff  = w_trial - w_d1;
        end else begin
            w_digit = 2'd0;
            w_diff  = w_trial;
        end
    end

    // quotient digits enter at the bottom as numerator digits leave the top
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_shift <= i_num;
                r_rem   <= '0;
                r_cnt   <= DIV_CNT_W'(DIV_DIGITS - 1);
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                r_shift <= {r_shift[DIV_NUM_W-3:0], w_digit};
                r_rem   <= w_diff[DIV_DEN_W-1:0];
                r_cnt   <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_quot        = r_shift;
    assign o_stat.done   = r_done;
    assign o_stat.rem_nz = |r_rem;

endmodule

/* hdl/encoder_gyro_odometry.sv */
// Wheel-encoder and yaw-gyro odometry: one result per accepted sample set.
// A new sample set is taken only once the sequencer is back in idle; the wait is
// set by the 20 radix-4 steps of the serial dividers (low-pass by 10 and heading
// by 10^6 run side by side) and by a stalled result slot.
// Synchronous active-low reset clears all odometry state and restores the
// register reset values; no clearing pass is needed.
module encoder_gyro_odometry import egodo_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // sample channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [ENC_W-1:0]         i_right_angle,
    input  logic [ENC_W-1:0]         i_left_angle,
    input  logic signed [GYRO_W-1:0] i_gyro_yaw,
    // result channel
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [SPD_W-1:0]  o_body_speed,
    output logic signed [SPD_W-1:0]  o_last_body_speed,
    output logic signed [ACC_W-1:0]  o_speed_integral,
    output logic signed [ACC_W-1:0]  o_distance,
    output logic signed [SPD_W-1:0]  o_yaw_rate,
    output logic signed [SPD_W-1:0]  o_last_yaw_rate,
    output logic signed [ACC_W-1:0]  o_yaw_rate_integral,
    output logic signed [ACC_W-1:0]  o_heading,
    // register port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready
);

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_MUL, S_START, S_DIV, S_FIX, S_AVG, S_ACC
    } t_state;

    t_state r_state;
    t_cfg   w_cfg;

    // captured sample
    logic [ENC_W-1:0]         r_in_right;
    logic [ENC_W-1:0]         r_in_left;
    logic signed [GYRO_W-1:0] r_in_gyro;

    // odometry state
    logic [ENC_W-1:0]        r_prev_right;
    logic [ENC_W-1:0]        r_prev_left;
    logic signed [SPD_W-1:0] r_filt_r;
    logic signed [SPD_W-1:0] r_filt_l;
    logic signed [SPD_W-1:0] r_speed_now;
    logic signed [SPD_W-1:0] r_speed_before;
    logic signed [ACC_W-1:0] r_speed_sum;
    logic signed [ACC_W-1:0] r_travelled;
    logic signed [SPD_W-1:0] r_rate_now;
    logic signed [SPD_W-1:0] r_rate_before;
    logic signed [ACC_W-1:0] r_rate_sum;
    logic signed [ACC_W-1:0] r_yaw_angle;
    logic                    r_out_valid;

    // intermediates
    logic signed [RAW_W-1:0] r_raw_r;
    logic signed [RAW_W-1:0] r_raw_l;
    logic signed [G_W-1:0]   r_g;
    logic signed [LPN_W-1:0] r_num_r;
    logic signed [LPN_W-1:0] r_num_l;
    logic signed [HDN_W-1:0] r_num_h;
    logic signed [RR_W-1:0]  r_rr;
    logic                    r_start;
    logic                    r_neg_r;
    logic                    r_neg_l;
    logic                    r_neg_h;
    logic [DIV_NUM_W-1:0]    r_mag_r;
    logic [DIV_NUM_W-1:0]    r_mag_l;
    logic [DIV_NUM_W-1:0]    r_mag_h;
    logic signed [SPD_W-1:0] r_head_inc;
    logic signed [SPD_W-1:0] r_speed_new;
    logic signed [RAW_W-1:0] r_trav_inc;
    logic signed [SPD_W-1:0] r_rate_new;

    // next values
    logic signed [ENC_W-1:0]  n_delta_r;
    logic signed [ENC_W-1:0]  n_delta_l;
    logic signed [RAW_W-1:0]  n_raw_r;
    logic signed [RAW_W-1:0]  n_raw_l;
    logic signed [GDIF_W-1:0] n_gdiff;
    logic signed [G_W-1:0]    n_gext;
    logic signed [G_W-1:0]    n_g;
    logic signed [LPN_W-1:0]  n_fr;
    logic signed [LPN_W-1:0]  n_fl;
    logic signed [LPN_W-1:0]  n_num_r;
    logic signed [LPN_W-1:0]  n_num_l;
    logic signed [HDN_W-1:0]  n_num_h;
    logic signed [RR_W-1:0]   n_rr;
    logic signed [LPN_W-1:0]  n_abs_r;
    logic signed [LPN_W-1:0]  n_abs_l;
    logic signed [HDN_W-1:0]  n_abs_h;
    logic signed [DIV_NUM_W:0] n_q_r;
    logic signed [DIV_NUM_W:0] n_q_l;
    logic signed [DIV_NUM_W:0] n_q_h;
    logic signed [SPD_W:0]    n_fsum;
    logic signed [RAW_W:0]    n_rsum;
    logic signed [RR_W-1:0]   n_rr_b;
    logic signed [SPD_W-1:0]  n_speed_new;
    logic signed [RAW_W-1:0]  n_trav_inc;
    logic signed [SPD_W-1:0]  n_rate_new;
    logic signed [ACC_W-1:0]  n_speed_sum;
    logic signed [ACC_W-1:0]  n_travelled;
    logic signed [ACC_W-1:0]  n_rate_sum;
    logic signed [ACC_W-1:0]  n_yaw_angle;

    // divider side
    logic [DIV_NUM_W-1:0] w_quot_r;
    logic [DIV_NUM_W-1:0] w_quot_l;
    logic [DIV_NUM_W-1:0] w_quot_h;
    t_div_stat            w_stat_r;
    t_div_stat            w_stat_l;
    t_div_stat            w_stat_h;
    logic                 w_div_done;
    logic                 w_in_xfer;
    logic                 w_out_free;

    egodo_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    egodo_div u_div_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_num   (r_mag_r),
        .i_den   (LP_DEN),
        .o_quot  (w_quot_r),
        .o_stat  (w_stat_r)
    );

    egodo_div u_div_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_num   (r_mag_l),
        .i_den   (LP_DEN),
        .o_quot  (w_quot_l),
        .o_stat  (w_stat_l)
    );

    egodo_div u_div_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_num   (r_mag_h),
        .i_den   (HEAD_DEN),
        .o_quot  (w_quot_h),
        .o_stat  (w_stat_h)
    );

    assign w_div_done = w_stat_r.done && w_stat_l.done && w_stat_h.done;
    assign o_stall    = (r_state != S_IDLE);
    assign w_in_xfer  = i_valid && !o_stall;
    assign w_out_free = !(r_out_valid && i_stall);

    always_comb begin
        // right wheel runs mirrored, so its delta is taken the other way round
        n_delta_r = signed'(r_prev_right - r_in_right);
        n_delta_l = signed'(r_in_left - r_prev_left);
        n_raw_r   = n_delta_r * signed'({1'b0, w_cfg.mm_per_pulse});
        n_raw_l   = n_delta_l * signed'({1'b0, w_cfg.mm_per_pulse});
        n_gdiff   = signed'({w_cfg.gyro_offset[GYRO_W-1], w_cfg.gyro_offset}
                    - {r_in_gyro[GYRO_W-1], r_in_gyro});
        n_gext    = G_W'(n_gdiff);
        n_g       = (n_gext <<< 6) + (n_gext <<< 2) + (n_gext <<< 1);

        // low-pass numerators raw + 9*old + 5, heading numerator and yaw-rate product
        n_fr    = LPN_W'(r_filt_r);
        n_fl    = LPN_W'(r_filt_l);
        n_num_r = LPN_W'(r_raw_r) + (n_fr <<< 3) + n_fr + LP_BIAS;
        n_num_l = LPN_W'(r_raw_l) + (n_fl <<< 3) + n_fl + LP_BIAS;
        n_num_h = (HDN_W'(r_g) <<< FRAC_W) + HEAD_BIAS;
        n_rr    = r_g * signed'({1'b0, RAD_PER_MDEG_Q32});

        n_abs_r = r_num_r[LPN_W-1] ? -r_num_r : r_num_r;
        n_abs_l = r_num_l[LPN_W-1] ? -r_num_l : r_num_l;
        n_abs_h = r_num_h[HDN_W-1] ? -r_num_h : r_num_h;

        // floor of a negative quotient rounds away from zero on a remainder
        n_q_r = signed'({1'b0, w_quot_r}) + (DIV_NUM_W+1)'(w_stat_r.rem_nz && r_neg_r);
        n_q_l = signed'({1'b0, w_quot_l}) + (DIV_NUM_W+1)'(w_stat_l.rem_nz && r_neg_l);
        n_q_h = signed'({1'b0, w_quot_h}) + (DIV_NUM_W+1)'(w_stat_h.rem_nz && r_neg_h);
        if (r_neg_r) n_q_r = -n_q_r;
        if (r_neg_l) n_q_l = -n_q_l;
        if (r_neg_h) n_q_h = -n_q_h;

        n_fsum      = (SPD_W+1)'(r_filt_r) + (SPD_W+1)'(r_filt_l);
        n_speed_new = n_fsum[SPD_W:1];
        n_rsum      = (RAW_W+1)'(r_raw_r) + (RAW_W+1)'(r_raw_l);
        n_trav_inc  = n_rsum[RAW_W:1];
        n_rr_b      = r_rr + RATE_BIAS;
        n_rate_new  = SPD_W'(n_rr_b >>> RATE_SHIFT);

        n_speed_sum = sat_acc((ACC_W+1)'(r_speed_sum) + (ACC_W+1)'(r_speed_new));
        n_travelled = sat_acc((ACC_W+1)'(r_travelled) + (ACC_W+1)'(r_trav_inc));
        n_rate_sum  = sat_acc((ACC_W+1)'(r_rate_sum) + (ACC_W+1)'(r_rate_new));
        n_yaw_angle = sat_acc((ACC_W+1)'(r_yaw_angle) + (ACC_W+1)'(r_head_inc));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_start        <= 1'b0;
            r_out_valid    <= 1'b0;
            r_prev_right   <= '0;
            r_prev_left    <= '0;
            r_filt_r       <= '0;
            r_filt_l       <= '0;
            r_speed_now    <= '0;
            r_speed_before <= '0;
            r_speed_sum    <= '0;
            r_travelled    <= '0;
            r_rate_now     <= '0;
            r_rate_before  <= '0;
            r_rate_sum     <= '0;
            r_yaw_angle    <= '0;
        end else begin
            r_start <= (r_state == S_START);
            if ((r_state == S_ACC) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_in_right <= i_right_angle;
                        r_in_left  <= i_left_angle;
                        r_in_gyro  <= i_gyro_yaw;
                        r_state    <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_raw_r      <= n_raw_r;
                    r_raw_l      <= n_raw_l;
                    r_g          <= n_g;
                    r_prev_right <= r_in_right;
                    r_prev_left  <= r_in_left;
                    r_state      <= S_MUL;
                end
                S_MUL: begin
                    r_num_r <= n_num_r;
                    r_num_l <= n_num_l;
                    r_num_h <= n_num_h;
                    r_rr    <= n_rr;
                    r_state <= S_START;
                end
                S_START: begin
                    r_neg_r <= r_num_r[LPN_W-1];
                    r_neg_l <= r_num_l[LPN_W-1];
                    r_neg_h <= r_num_h[HDN_W-1];
                    r_mag_r <= DIV_NUM_W'(unsigned'(n_abs_r));
                    r_mag_l <= DIV_NUM_W'(unsigned'(n_abs_l));
                    r_mag_h <= n_abs_h[DIV_NUM_W-1:0];
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    r_filt_r   <= n_q_r[SPD_W-1:0];
                    r_filt_l   <= n_q_l[SPD_W-1:0];
                    r_head_inc <= n_q_h[SPD_W-1:0];
                    r_state    <= S_AVG;
                end
                S_AVG: begin
                    r_speed_new <= n_speed_new;
                    r_trav_inc  <= n_trav_inc;
                    r_rate_new  <= n_rate_new;
                    r_state     <= S_ACC;
                end
                S_ACC: begin
                    // state doubles as the output register; commit once the slot is free
                    if (w_out_free) begin
                        r_speed_before <= r_speed_now;
                        r_speed_now    <= r_speed_new;
                        r_speed_sum    <= n_speed_sum;
                        r_travelled    <= n_travelled;
                        r_rate_before  <= r_rate_now;
                        r_rate_now     <= r_rate_new;
                        r_rate_sum     <= n_rate_sum;
                        r_yaw_angle    <= n_yaw_angle;
                        r_state        <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_valid             = r_out_valid;
    assign o_body_speed        = r_speed_now;
    assign o_last_body_speed   = r_speed_before;
    assign o_speed_integral    = r_speed_sum;
    assign o_distance          = r_travelled;
    assign o_yaw_rate          = r_rate_now;
    assign o_last_yaw_rate     = r_rate_before;
    assign o_yaw_rate_integral = r_rate_sum;
    assign o_heading           = r_yaw_angle;

endmodule

/* hdl/egodo_chk.sv */
// Port-level checker for encoder_gyro_odometry, attached by bind.
// No package dependency.
module egodo_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_body_speed,
    input logic signed [47:0] o_speed_integral,
    input logic signed [47:0] o_heading
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_body_speed) && $stable(o_speed_integral)
            && $stable(o_heading))
        else $error("result changed while stalled");

    // an input transfer starts a busy period at once
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken without going busy");

    // a new result is published only as the sequencer returns to idle
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !o_stall)
        else $error("result published while still busy");

endmodule

bind encoder_gyro_odometry egodo_chk u_egodo_chk (.*);
